### sv/block_mean_ascii_quantizer_core_defines.svh
// Assertion macros shared by the quantizer RTL.
// Needs nothing but a clk and an active-low rst_n in the including module.
`ifndef BLOCK_MEAN_ASCII_QUANTIZER_CORE_DEFINES_SVH
`define BLOCK_MEAN_ASCII_QUANTIZER_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BMAQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BMAQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bmaq_pkg.sv
// Types, register codes and classification tables of the ASCII mosaic quantizer.
// Used by every module of the block but bmaq_ram; depends on nothing.
package bmaq_pkg;

  localparam int SUM_W = 32;

  typedef enum logic [1:0] {
    REG_TILE_WIDTH    = 2'd0,
    REG_TILE_HEIGHT   = 2'd1,
    REG_TILES_PER_ROW = 2'd2,
    REG_BRIGHTNESS    = 2'd3
  } reg_idx_t;

  localparam logic [6:0] RST_TILE_WIDTH    = 7'd7;
  localparam logic [6:0] RST_TILE_HEIGHT   = 7'd15;
  localparam logic [8:0] RST_TILES_PER_ROW = 9'd64;
  localparam logic [7:0] RST_BRIGHTNESS    = 8'd80;

  typedef struct packed {
    logic [6:0] tile_width;
    logic [6:0] tile_height;
    logic [8:0] tiles_per_row;
    logic [7:0] brightness_offset;
  } cfg_regs_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             row_end;
  } tile_sum_t;

  localparam int NUM_THRESH = 5;
  localparam int CLASS_W    = 3;

  // Mean thresholds, darkest class first.
  localparam logic [7:0] THRESH [NUM_THRESH] = '{8'd150, 8'd170, 8'd190, 8'd200, 8'd225};

  localparam logic [6:0] GLYPH_AT    = 7'h40;
  localparam logic [6:0] GLYPH_HASH  = 7'h23;
  localparam logic [6:0] GLYPH_STAR  = 7'h2A;
  localparam logic [6:0] GLYPH_PLUS  = 7'h2B;
  localparam logic [6:0] GLYPH_DOT   = 7'h2E;
  localparam logic [6:0] GLYPH_SPACE = 7'h20;

  localparam logic [6:0] GLYPHS [NUM_THRESH+1] =
    '{GLYPH_AT, GLYPH_HASH, GLYPH_STAR, GLYPH_PLUS, GLYPH_DOT, GLYPH_SPACE};
  localparam logic [7:0] FILLS [NUM_THRESH+1] =
    '{8'd0, 8'd155, 8'd200, 8'd200, 8'd230, 8'd255};

  // A zero setting counts as one and anything above the limit as the limit.
  function automatic logic [15:0] clamp_range(logic [8:0] v, logic [15:0] hi);
    logic [15:0] wide;
    wide = {7'b0, v};
    if (v == 9'd0) return 16'd1;
    if (wide > hi) return hi;
    return wide;
  endfunction

endpackage

### sv/bmaq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; a read at the address being written returns the old word.
module bmaq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bmaq_cfg.sv
// APB-style register file holding the four quantizer settings.
// Depends on bmaq_pkg for the register codes and the settings struct.
module bmaq_cfg import bmaq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      wr_en;
  reg_idx_t  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_TILE_WIDTH:    cfg_nxt.tile_width        = pwdata[6:0];
        REG_TILE_HEIGHT:   cfg_nxt.tile_height       = pwdata[6:0];
        REG_TILES_PER_ROW: cfg_nxt.tiles_per_row     = pwdata[8:0];
        REG_BRIGHTNESS:    cfg_nxt.brightness_offset = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_width        <= RST_TILE_WIDTH;
      cfg_r.tile_height       <= RST_TILE_HEIGHT;
      cfg_r.tiles_per_row     <= RST_TILES_PER_ROW;
      cfg_r.brightness_offset <= RST_BRIGHTNESS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TILE_WIDTH:    prdata = {25'b0, cfg_r.tile_width};
      REG_TILE_HEIGHT:   prdata = {25'b0, cfg_r.tile_height};
      REG_TILES_PER_ROW: prdata = {23'b0, cfg_r.tiles_per_row};
      REG_BRIGHTNESS:    prdata = {24'b0, cfg_r.brightness_offset};
      default:           prdata = 32'b0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### sv/bmaq_accum.sv
// Raster position counters, brightness offset and per-column tile sums.
// Depends on bmaq_pkg, bmaq_ram and the assertion macros header.
`include "block_mean_ascii_quantizer_core_defines.svh"
module bmaq_accum import bmaq_pkg::*; #(
  parameter int MAX_TILES_PER_ROW = 256,
  parameter int MAX_TILE_SIDE     = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_pixel,
  output logic       sum_vld,
  input  logic       sum_rdy,
  output tile_sum_t  sum_out
);

  localparam int IW = (MAX_TILES_PER_ROW > 1) ? $clog2(MAX_TILES_PER_ROW) : 1;
  localparam int CW = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;

  logic [15:0] w_c, h_c, n_c;
  logic [CW-1:0] w_m1, h_m1;
  logic [IW-1:0] n_m1;

  assign w_c  = clamp_range({2'b00, cfg.tile_width}, 16'(MAX_TILE_SIDE));
  assign h_c  = clamp_range({2'b00, cfg.tile_height}, 16'(MAX_TILE_SIDE));
  assign n_c  = clamp_range(cfg.tiles_per_row, 16'(MAX_TILES_PER_ROW));
  assign w_m1 = CW'(w_c - 16'd1);
  assign h_m1 = CW'(h_c - 16'd1);
  assign n_m1 = IW'(n_c - 16'd1);

  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          last_col, last_row, last_tile;
  logic          in_fire;
  logic [8:0]    v_wide;
  logic [7:0]    v_sat;

  assign in_fire   = in_tvalid && in_tready;
  assign last_col  = col_r >= w_m1;
  assign last_row  = row_r >= h_m1;
  assign last_tile = idx_r >= n_m1;
  assign v_wide    = {1'b0, in_pixel} + {1'b0, cfg.brightness_offset};
  assign v_sat     = v_wide[8] ? 8'hFF : v_wide[7:0];

  // A counter at or past its last value wraps, so a setting that shrinks
  // between frames never strands a counter out of range.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    idx_nxt = idx_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_tile) begin
          idx_nxt = '0;
          row_nxt = last_row ? '0 : row_r + CW'(1);
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // Stage 1 holds the request while the tile sum is read from the RAM.
  logic          s1_vld_r, s1_vld_nxt;
  logic [7:0]    s1_pix_r;
  logic [IW-1:0] s1_idx_r;
  logic          s1_clr_r, s1_fire_r, s1_last_r;
  logic          s1_go;

  assign s1_go      = s1_vld_r && (!s1_fire_r || sum_rdy);
  assign in_tready  = !s1_vld_r || s1_go;
  assign s1_vld_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_vld_r);

  logic [SUM_W-1:0] ram_rdata, old_sum, sum_new;
  logic [MAX_TILES_PER_ROW-1:0] valid_r, valid_nxt;
  logic             fwd_vld_r;
  logic [IW-1:0]    fwd_idx_r;
  logic [SUM_W-1:0] fwd_sum_r;

  bmaq_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_TILES_PER_ROW)
  ) u_sums (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_idx_r),
    .wdata (sum_new),
    .re    (in_fire),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // The previous request may have written this entry on the edge the read
  // was taken, so its sum is forwarded; never-written entries read as zero.
  always_comb begin
    if (fwd_vld_r && (fwd_idx_r == s1_idx_r)) begin
      old_sum = fwd_sum_r;
    end else if (valid_r[s1_idx_r]) begin
      old_sum = ram_rdata;
    end else begin
      old_sum = '0;
    end
    sum_new = s1_clr_r ? SUM_W'(s1_pix_r) : old_sum + SUM_W'(s1_pix_r);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s1_go) begin
      valid_nxt[s1_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      idx_r     <= '0;
      s1_vld_r  <= 1'b0;
      valid_r   <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      idx_r    <= idx_nxt;
      s1_vld_r <= s1_vld_nxt;
      valid_r  <= valid_nxt;
      if (s1_go) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= v_sat;
      s1_idx_r  <= idx_r;
      s1_clr_r  <= (row_r == '0) && (col_r == '0);
      s1_fire_r <= last_col && last_row;
      s1_last_r <= last_tile;
    end
    if (s1_go) begin
      fwd_idx_r <= s1_idx_r;
      fwd_sum_r <= sum_new;
    end
  end

  assign sum_vld = s1_vld_r && s1_fire_r;
  assign sum_out = '{sum: sum_new, row_end: s1_last_r};

  `BMAQ_ASSERT(a_stall_holds, s1_vld_r && !s1_go |=> s1_vld_r && $stable(s1_idx_r), "stalled request lost")
  `BMAQ_ASSERT(a_no_accept_blocked, sum_vld && !sum_rdy |-> !in_tready, "accepted while tile result blocked")
  `BMAQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> valid_r == '0 && !fwd_vld_r, "sum valid bits not cleared")
  `BMAQ_ASSERT(a_fwd_marked, fwd_vld_r |-> valid_r[fwd_idx_r], "forwarded entry not marked written")

endmodule

### sv/bmaq_classify.sv
// Tile mean classification against scaled thresholds, with the result register.
// Depends on bmaq_pkg for the sum struct, thresholds and glyph tables.
module bmaq_classify import bmaq_pkg::*; #(
  parameter int MAX_TILE_SIDE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       sum_vld,
  output logic       sum_rdy,
  input  tile_sum_t  sum_in,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [6:0] out_glyph,
  output logic [7:0] out_fill,
  output logic       out_row_end
);

  localparam int PW = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);
  localparam int TW = PW + 8;

  logic [15:0]   w_c, h_c;
  logic [PW-1:0] pix_r;
  logic [TW-1:0] thr_r [NUM_THRESH];

  assign w_c = clamp_range({2'b00, cfg.tile_width}, 16'(MAX_TILE_SIDE));
  assign h_c = clamp_range({2'b00, cfg.tile_height}, 16'(MAX_TILE_SIDE));

  // The user must change settings only while idle (unchecked); products settle.
  always_ff @(posedge clk) begin
    pix_r <= PW'({16'b0, w_c} * {16'b0, h_c});
    for (int i = 0; i < NUM_THRESH; i++) begin
      thr_r[i] <= TW'({24'b0, THRESH[i]} * 32'(pix_r));
    end
  end

  logic      s2_vld_r, s2_vld_nxt;
  tile_sum_t s2_r;
  logic      s2_go;
  logic      out_vld_r, out_vld_nxt;
  logic [6:0] out_glyph_r;
  logic [7:0] out_fill_r;
  logic       out_last_r;
  logic [CLASS_W-1:0] cls;

  assign s2_go       = s2_vld_r && (!out_vld_r || out_tready);
  assign sum_rdy     = !s2_vld_r || s2_go;
  assign s2_vld_nxt  = (sum_vld && sum_rdy) ? 1'b1 : (s2_go ? 1'b0 : s2_vld_r);
  assign out_vld_nxt = s2_go ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  // The darkest threshold that the sum stays below picks the class.
  always_comb begin
    cls = CLASS_W'(NUM_THRESH);
    for (int i = NUM_THRESH - 1; i >= 0; i--) begin
      if (s2_r.sum < SUM_W'(thr_r[i])) begin
        cls = CLASS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld && sum_rdy) begin
      s2_r <= sum_in;
    end
    if (s2_go) begin
      out_glyph_r <= GLYPHS[cls];
      out_fill_r  <= FILLS[cls];
      out_last_r  <= s2_r.row_end;
    end
  end

  assign out_tvalid  = out_vld_r;
  assign out_glyph   = out_glyph_r;
  assign out_fill    = out_fill_r;
  assign out_row_end = out_last_r;

endmodule

### sv/block_mean_ascii_quantizer_core.sv
// Top level of the block-mean ASCII mosaic quantizer; built from bmaq_cfg,
// bmaq_accum and bmaq_classify, with types from bmaq_pkg. It takes one
// grayscale pixel per clock in raster order, sustained, and a stalled output
// only stops input once both result slots are full. The rate is set by the
// tile-sum RAM, which gets one read and one write each cycle, with the last
// written sum forwarded. A tile's result passes the stage-1 register, the
// classifier's sum register and the result register. Pixels that end no
// tile give no result. No clearing pass is needed after reset: a sum is
// cleared on its tile's first pixel and unwritten entries read as zero.
module block_mean_ascii_quantizer_core import bmaq_pkg::*; #(
  parameter int MAX_TILES_PER_ROW = 256,
  parameter int MAX_TILE_SIDE     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [6:0] glyph, [14:7] fill_level, [15] zero
  output logic        out_tlast,    // row_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_regs_t  cfg;
  logic       sum_vld, sum_rdy;
  tile_sum_t  tile_sum;
  logic [6:0] glyph;
  logic [7:0] fill_level;

  bmaq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bmaq_accum #(
    .MAX_TILES_PER_ROW (MAX_TILES_PER_ROW),
    .MAX_TILE_SIDE     (MAX_TILE_SIDE)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pixel  (in_tdata),
    .sum_vld   (sum_vld),
    .sum_rdy   (sum_rdy),
    .sum_out   (tile_sum)
  );

  bmaq_classify #(
    .MAX_TILE_SIDE (MAX_TILE_SIDE)
  ) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .sum_vld     (sum_vld),
    .sum_rdy     (sum_rdy),
    .sum_in      (tile_sum),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_glyph   (glyph),
    .out_fill    (fill_level),
    .out_row_end (out_tlast)
  );

  assign out_tdata = {1'b0, fill_level, glyph};

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for block_mean_ascii_quantizer_core. It streams pixels through the
// block with random gaps and back pressure, predicts each tile's glyph and fill
// level, and checks them in order. Depends on bmaq_pkg and the core RTL only.
module tb;
  import bmaq_pkg::*;

  localparam int SIDE_LIMIT       = 64;
  localparam int ROW_LIMIT        = 256;
  localparam int RESULT_LATENCY   = 2;
  localparam int STALL_LIMIT      = 3000;
  localparam int RANDOM_PIXELS    = 550;
  localparam int HOLD_OFF_CYCLES  = 300;

  typedef struct {
    logic [6:0] glyph;
    logic [7:0] fill;
    logic       row_end;
  } tile_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // [7:0] pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [6:0] glyph, [14:7] fill_level, [15] zero
  logic        out_tlast;           // row_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the registers and of the tile accumulator state.
  logic [6:0] tile_w_reg = 7'd7;
  logic [6:0] tile_h_reg = 7'd15;
  logic [8:0] tiles_reg  = 9'd64;
  logic [7:0] offset_reg = 8'd80;
  int         tile_sum [ROW_LIMIT];
  int         col_pos;
  int         row_pos;
  int         tile_pos;

  tile_result_t expected_tiles[$];

  int errors;
  int pixels_sent;
  int tiles_checked;
  int reg_writes;
  int stalled_cycles;
  bit tx_gaps;
  bit rx_gaps;
  int rx_hold;

  block_mean_ascii_quantizer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic int effective_size(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void report_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // Adds one accepted pixel to its tile and queues the tile's result when the
  // pixel closes it.
  function automatic void accumulate_pixel(logic [7:0] pixel);
    int w, h, n, level, idx, pix, sum;
    bit last_col, last_row, last_tile;
    tile_result_t res;
    w = effective_size(int'(tile_w_reg), SIDE_LIMIT);
    h = effective_size(int'(tile_h_reg), SIDE_LIMIT);
    n = effective_size(int'(tiles_reg), ROW_LIMIT);
    level = int'(pixel) + int'(offset_reg);
    if (level > 255) level = 255;
    idx = (tile_pos >= ROW_LIMIT) ? ROW_LIMIT - 1 : tile_pos;
    if (row_pos == 0 && col_pos == 0) tile_sum[idx] = level;
    else tile_sum[idx] += level;
    last_col  = col_pos >= w - 1;
    last_row  = row_pos >= h - 1;
    last_tile = tile_pos >= n - 1;
    if (last_col && last_row) begin
      sum = tile_sum[idx];
      pix = w * h;
      if (sum < 150 * pix) begin
        res.glyph = GLYPH_AT;
        res.fill  = 8'd0;
      end else if (sum < 170 * pix) begin
        res.glyph = GLYPH_HASH;
        res.fill  = 8'd155;
      end else if (sum < 190 * pix) begin
        res.glyph = GLYPH_STAR;
        res.fill  = 8'd200;
      end else if (sum < 200 * pix) begin
        res.glyph = GLYPH_PLUS;
        res.fill  = 8'd200;
      end else if (sum < 225 * pix) begin
        res.glyph = GLYPH_DOT;
        res.fill  = 8'd230;
      end else begin
        res.glyph = GLYPH_SPACE;
        res.fill  = 8'd255;
      end
      res.row_end = last_tile;
      expected_tiles.push_back(res);
    end
    // Counters past a shrunken limit count as last and wrap.
    if (last_col) begin
      col_pos = 0;
      if (last_tile) begin
        tile_pos = 0;
        row_pos = last_row ? 0 : row_pos + 1;
      end else begin
        tile_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic [31:0] register_value(reg_idx_t r);
    case (r)
      REG_TILE_WIDTH:    return {25'd0, tile_w_reg};
      REG_TILE_HEIGHT:   return {25'd0, tile_h_reg};
      REG_TILES_PER_ROW: return {23'd0, tiles_reg};
      default:           return {24'd0, offset_reg};
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] pixel);
    int gap;
    gap = tx_gaps ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pixel;
    do @(posedge clk); while (!in_tready);
    accumulate_pixel(pixel);
    pixels_sent++;
  endtask

  // Stops the input and waits until every tile result is back and the
  // pipeline has had time to finish any pixel that closes no tile.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 5) @(posedge clk);
  endtask

  task automatic apb_access(input bit write, input reg_idx_t r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t r);
    logic [31:0] rd;
    apb_access(1'b0, r, 32'd0, rd);
    if (rd !== register_value(r))
      report_mismatch($sformatf("register %s read %h, expected %h", r.name(), rd,
                                register_value(r)));
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, r, value, rd);
    case (r)
      REG_TILE_WIDTH:    tile_w_reg = value[6:0];
      REG_TILE_HEIGHT:   tile_h_reg = value[6:0];
      REG_TILES_PER_ROW: tiles_reg  = value[8:0];
      default:           offset_reg = value[7:0];
    endcase
    reg_writes++;
    check_reg(r);
  endtask

  task automatic configure(input int w, input int h, input int n, input int offset);
    write_reg(REG_TILE_WIDTH, w);
    write_reg(REG_TILE_HEIGHT, h);
    write_reg(REG_TILES_PER_ROW, n);
    write_reg(REG_BRIGHTNESS, offset);
  endtask

  // Target tile mean: usually just around one of the class thresholds.
  function automatic int pick_level();
    int base;
    if ($urandom_range(0, 9) >= 7) return $urandom_range(60, 255);
    case ($urandom_range(0, 4))
      0:       base = 150;
      1:       base = 170;
      2:       base = 190;
      3:       base = 200;
      default: base = 225;
    endcase
    return base + $urandom_range(0, 4) - 2;
  endfunction

  function automatic logic [7:0] pixel_for(int level);
    int p;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    p = level - int'(offset_reg) + $urandom_range(0, 10) - 5;
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return 8'(p);
  endfunction

  task automatic send_run(input int count);
    int block, level;
    block = effective_size(int'(tile_w_reg), SIDE_LIMIT) *
            effective_size(int'(tile_h_reg), SIDE_LIMIT);
    level = pick_level();
    for (int i = 0; i < count; i++) begin
      if (i % block == 0) level = pick_level();
      send_pixel(pixel_for(level));
    end
  endtask

  task automatic test_reset_values();
    check_reg(REG_TILE_WIDTH);
    check_reg(REG_TILE_HEIGHT);
    check_reg(REG_TILES_PER_ROW);
    check_reg(REG_BRIGHTNESS);
  endtask

  // Single-pixel tiles put every class boundary on an exact pixel value.
  task automatic test_class_boundaries();
    int edges [12] = '{0, 149, 150, 169, 170, 189, 190, 199, 200, 224, 225, 255};
    configure(1, 1, 3, 0);
    foreach (edges[i]) send_pixel(8'(edges[i]));
    drain();
    // Two-pixel tiles: one sum just below and one exactly on 150 per pixel.
    configure(2, 1, 1, 0);
    send_pixel(8'd149);
    send_pixel(8'd150);
    send_pixel(8'd149);
    send_pixel(8'd151);
    drain();
  endtask

  task automatic test_saturation();
    configure(1, 1, 2, 255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();
    write_reg(REG_BRIGHTNESS, 200);
    send_pixel(8'd55);
    send_pixel(8'd24);
    drain();
  endtask

  // Zero sizes behave as one, so each pixel is a tile that ends its row.
  task automatic test_zero_sizes();
    configure(0, 0, 0, 80);
    send_pixel(8'd70);
    send_pixel(8'd200);
    drain();
  endtask

  // Shrinking the tile or the row while the counters are part way through.
  task automatic test_midframe_change();
    configure(4, 2, 2, 80);
    send_run(6);
    drain();
    write_reg(REG_TILE_WIDTH, 2);
    send_run(3);
    drain();
    write_reg(REG_TILES_PER_ROW, 1);
    write_reg(REG_TILE_HEIGHT, 1);
    send_run(4);
    drain();
  endtask

  // The receiver stops for a long stretch while pixels keep coming, so the
  // result slots fill and the block has to hold off input requests.
  task automatic test_backpressure();
    configure(1, 1, 5, 30);
    tx_gaps = 0;
    rx_gaps = 0;
    rx_hold = HOLD_OFF_CYCLES;
    send_run(40);
    drain();
  endtask

  // Oversize sides clamp to the limit on one axis at a time.
  task automatic test_large_tiles();
    tx_gaps = 1;
    rx_gaps = 1;
    configure(127, 4, 1, $urandom_range(0, 255));
    send_run(SIDE_LIMIT * 4);
    drain();
    configure(2, 127, 1, $urandom_range(0, 255));
    send_run(SIDE_LIMIT * 2);
    drain();
    configure(64, 2, 2, $urandom_range(0, 255));
    send_run(256);
    drain();
    configure(1, 1, 511, $urandom_range(0, 255));
    send_run(ROW_LIMIT);
    drain();
    configure(1, 1, 256, $urandom_range(0, 255));
    send_run(ROW_LIMIT + 3);
    drain();
  endtask

  function automatic int pick_side();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 4);
    if (r == 8) return $urandom_range(5, 12);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return SIDE_LIMIT;
      default: return $urandom_range(SIDE_LIMIT + 1, 127);
    endcase
  endfunction

  function automatic int pick_row_tiles();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 6);
    if (r == 8) return $urandom_range(7, 20);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return ROW_LIMIT;
      default: return $urandom_range(ROW_LIMIT + 1, 511);
    endcase
  endfunction

  // Mostly whole frames with random content; now and then a short broken run
  // that leaves the counters mid-tile for the next setting.
  task automatic test_random_frames();
    int phase, start_px, w, h, n, offset, frame, count, r;
    phase = 0;
    start_px = pixels_sent;
    while (pixels_sent - start_px < RANDOM_PIXELS) begin
      tx_gaps = phase[0];
      rx_gaps = phase[1];
      w = pick_side();
      h = pick_side();
      n = pick_row_tiles();
      r = $urandom_range(0, 9);
      offset = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
      configure(w, h, n, offset);
      frame = effective_size(w, SIDE_LIMIT) * effective_size(h, SIDE_LIMIT) *
              effective_size(n, ROW_LIMIT);
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, 20);
      else count = frame * $urandom_range(1, 2);
      if (count > 200) count = 200;
      send_run(count);
      drain();
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_class_boundaries();
    test_saturation();
    test_zero_sizes();
    test_midframe_change();
    test_backpressure();
    test_large_tiles();
    test_random_frames();
    drain();
    $display("Run covered %0d pixels, %0d tile results and %0d register writes,",
             pixels_sent, tiles_checked, reg_writes);
    $display("with tile sides from 1 to 64, up to 256 tiles per row and stalls on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Verification failed");
    end
    $finish;
  end

  // Result consumer: random stalls, plus one long hold-off on request.
  initial begin
    int wait_left;
    wait_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_gaps) wait_left = gap_length();
      end
    end
  end

  always @(posedge clk) begin
    tile_result_t exp_tile;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tiles.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata %h tlast %b", out_tdata, out_tlast));
      end else begin
        exp_tile = expected_tiles.pop_front();
        if (out_tdata !== {1'b0, exp_tile.fill, exp_tile.glyph} ||
            out_tlast !== exp_tile.row_end)
          report_mismatch($sformatf(
            "tile %0d: expected glyph %h fill %0d row_end %b, got tdata %h tlast %b",
            tiles_checked, exp_tile.glyph, exp_tile.fill, exp_tile.row_end,
            out_tdata, out_tlast));
      end
      tiles_checked++;
    end
  end

  // Ends the run when no request of any kind has been accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles, %0d results outstanding",
               stalled_cycles, expected_tiles.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule

### block_mean_ascii_quantizer_core.f
+incdir+sv
sv/bmaq_pkg.sv
sv/bmaq_ram.sv
sv/bmaq_cfg.sv
sv/bmaq_accum.sv
sv/bmaq_classify.sv
sv/block_mean_ascii_quantizer_core.sv
test/tb.sv
